// File: rtl/hcmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmc_pkg
// shared types and constants for the hsv color mask centroid block
// ----------------------------------------------------------------------------
package hcmc_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int CoordW    = $clog2(MaxWidth > MaxHeight ? MaxWidth : MaxHeight);
	localparam int SizeW     = 11;
	localparam int SumW      = 30;
	localparam int CountW    = 21;
	localparam int QueueDepth = 4;

	localparam logic [1:0] RegPreset = 2'd0;
	localparam logic [1:0] RegWidth  = 2'd1;
	localparam logic [1:0] RegHeight = 2'd2;

	typedef struct packed {
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic              hit;
		logic              last;
		logic [CoordW-1:0] col;
		logic [CoordW-1:0] row;
	} item_t;

	function automatic logic [8:0] hue_low(input logic [1:0] p);
		case (p)
			2'd0: hue_low = 9'd45;
			2'd1: hue_low = 9'd64;
			2'd2: hue_low = 9'd180;
			default: hue_low = 9'd11;
		endcase
	endfunction

	function automatic logic [8:0] hue_high(input logic [1:0] p);
		case (p)
			2'd0: hue_high = 9'd64;
			2'd1: hue_high = 9'd150;
			2'd2: hue_high = 9'd255;
			default: hue_high = 9'd351;
		endcase
	endfunction

endpackage

// File: rtl/hcmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmc_front
// two-stage pixel classifier with raster position tracking
// ----------------------------------------------------------------------------
module hcmc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  ready,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	input  logic [1:0]            preset,
	input  logic [hcmc_pkg::SizeW-1:0] fw,
	input  logic [hcmc_pkg::SizeW-1:0] fh,
	output logic                  item_valid,
	input  logic                  item_ready,
	output hcmc_pkg::item_t       item
);
	localparam int CW = hcmc_pkg::CoordW;

	logic              v_s1, v_s2;
	logic [7:0]        r_s1, g_s1, b_s1, r_s2, g_s2, b_s2;
	logic [8:0]        mx_s1, dl_s1;
	logic signed [9:0] diff_s1;
	logic [2:0]        sect_s1;
	logic [CW-1:0]     col_s1, row_s1, col_s2, row_s2;
	logic              last_s1, last_s2, hit_s2;
	logic [CW-1:0]     col_q, row_q;
	logic [7:0]        mx, mn;
	logic signed [9:0] diff;
	logic [2:0]        sect;
	logic [CW:0]       w_eff, h_eff;
	logic              row_end, last;
	logic signed [19:0] hnum, d360;
	logic [17:0]       lo, hi;
	logic              hue_ok, sat_ok, hit;
	logic              adv1, adv2;

	always_comb begin
		if (red > green) begin
			if (red > blue) begin
				mx = red; diff = 10'(signed'({2'b0, green})) - 10'(signed'({2'b0, blue}));
				sect = 3'd0; mn = (green > blue) ? blue : green;
			end else begin
				mx = blue; diff = $signed({2'b0, red}) - $signed({2'b0, green});
				mn = green; sect = 3'd4;
			end
		end else if (red > blue) begin
			mx = green; diff = $signed({2'b0, blue}) - $signed({2'b0, red});
			mn = blue; sect = 3'd2;
		end else if (green > blue) begin
			mx = green; diff = $signed({2'b0, blue}) - $signed({2'b0, red});
			mn = red; sect = 3'd2;
		end else begin
			mx = blue; diff = $signed({2'b0, red}) - $signed({2'b0, green});
			mn = red; sect = 3'd4;
		end
	end

	always_comb begin
		w_eff = (fw == '0) ? (CW+1)'(1) : (fw > hcmc_pkg::SizeW'(hcmc_pkg::MaxWidth))
			? (CW+1)'(hcmc_pkg::MaxWidth) : (CW+1)'(fw);
		h_eff = (fh == '0) ? (CW+1)'(1) : (fh > hcmc_pkg::SizeW'(hcmc_pkg::MaxHeight))
			? (CW+1)'(hcmc_pkg::MaxHeight) : (CW+1)'(fh);
		row_end = {1'b0, col_q} >= w_eff - (CW+1)'(1);
		last = row_end && ({1'b0, row_q} >= h_eff - (CW+1)'(1));
	end

	always_comb begin
		hnum = 20'sd60 * ($signed({17'b0, sect_s1}) * $signed({11'b0, dl_s1})
			+ 20'(diff_s1));
		d360 = 20'sd360 * $signed({11'b0, dl_s1});
		if (hnum < 0) hnum = hnum + d360;
		if (hnum > d360) hnum = hnum - d360;
		lo = hcmc_pkg::hue_low(preset) * dl_s1;
		hi = hcmc_pkg::hue_high(preset) * dl_s1;
		hue_ok = (hnum > $signed({2'b0, lo})) && (hnum < $signed({2'b0, hi}));
		if (preset == 2'd3) sat_ok = 13'(dl_s1) * 13'd10 > 13'(mx_s1) * 13'd7;
		else sat_ok = 15'(dl_s1) * 15'd100 > 15'(mx_s1) * 15'd15;
		hit = (dl_s1 != '0) && (mx_s1 != '0) && hue_ok && sat_ok;
	end

	assign adv2  = !v_s2 || item_ready;
	assign adv1  = !v_s1 || adv2;
	assign ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; col_q <= '0; row_q <= '0;
		end else begin
			if (adv2) v_s2 <= v_s1;
			if (adv1) v_s1 <= valid;
			if (valid && adv1) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= last ? '0 : row_q + CW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			r_s1 <= red; g_s1 <= green; b_s1 <= blue;
			mx_s1 <= {1'b0, mx}; dl_s1 <= {1'b0, mx - mn};
			diff_s1 <= diff; sect_s1 <= sect;
			col_s1 <= col_q; row_s1 <= row_q; last_s1 <= last;
		end
		if (adv2) begin
			r_s2 <= r_s1; g_s2 <= g_s1; b_s2 <= b_s1; hit_s2 <= hit;
			col_s2 <= col_s1; row_s2 <= row_s1; last_s2 <= last_s1;
		end
	end

	assign item_valid = v_s2;
	assign item = '{red: r_s2, green: g_s2, blue: b_s2, hit: hit_s2, last: last_s2,
		col: col_s2, row: row_s2};
endmodule

// File: rtl/hcmc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmc_queue
// small fifo between classifier and accumulator
// ----------------------------------------------------------------------------
module hcmc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  hcmc_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output hcmc_pkg::item_t out_item
);
	localparam int AW = $clog2(hcmc_pkg::QueueDepth);

	hcmc_pkg::item_t mem_q [hcmc_pkg::QueueDepth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            wr, rd;

	assign in_ready  = cnt_q != (AW+1)'(hcmc_pkg::QueueDepth);
	assign out_valid = cnt_q != '0;
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;
	assign out_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + AW'(1);
			if (rd) rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_item;
	end
endmodule

// File: rtl/hcmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmc_back
// hit accumulation, serial centroid divide and result register
// ----------------------------------------------------------------------------
module hcmc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  hcmc_pkg::item_t item,
	output logic            valid,
	input  logic            ready,
	output logic [7:0]      out_red,
	output logic [7:0]      out_green,
	output logic [7:0]      out_blue,
	output logic            pixel_hit,
	output logic            frame_end,
	output logic            centroid_valid,
	output logic [9:0]      centroid_x,
	output logic [9:0]      centroid_y
);
	localparam int SW = hcmc_pkg::SumW;
	localparam int NW = hcmc_pkg::CountW;
	localparam int KW = $clog2(SW + 1);

	typedef enum logic [1:0] {RUN, DIV, SEND} state_t;
	state_t         state_q;
	logic [SW-1:0]  sx_q, sy_q, qx_q, qy_q;
	logic [NW-1:0]  n_q;
	logic [NW:0]    rx_q, ry_q, tx, ty;
	logic [KW-1:0]  k_q;
	logic [9:0]     hx_q, hy_q;
	logic           take;
	logic [SW-1:0]  sx_n, sy_n;
	logic [NW-1:0]  n_n;

	assign item_ready = (state_q == RUN) && (!valid || ready);
	assign take = item_valid && item_ready;

	always_comb begin
		sx_n = sx_q + (item.hit ? SW'(item.col) : '0);
		sy_n = sy_q + (item.hit ? SW'(item.row) : '0);
		n_n  = n_q + NW'(item.hit);
		tx = {rx_q[NW-1:0], qx_q[SW-1]};
		ty = {ry_q[NW-1:0], qy_q[SW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RUN; valid <= 1'b0; sx_q <= '0; sy_q <= '0; n_q <= '0;
			hx_q <= '0; hy_q <= '0;
			qx_q <= '0; qy_q <= '0; rx_q <= '0; ry_q <= '0; k_q <= '0;
			out_red <= '0; out_green <= '0; out_blue <= '0;
			pixel_hit <= 1'b0; frame_end <= 1'b0; centroid_valid <= 1'b0;
			centroid_x <= '0; centroid_y <= '0;
		end else begin
			unique case (state_q)
				RUN: begin
					if (take) begin
						out_red <= item.hit ? item.red : '0;
						out_green <= item.hit ? item.green : '0;
						out_blue <= item.hit ? item.blue : '0;
						pixel_hit <= item.hit;
						frame_end <= item.last;
						centroid_valid <= item.last && (n_n != '0);
						if (item.last && n_n != '0) begin
							qx_q <= sx_n; qy_q <= sy_n; n_q <= n_n;
							rx_q <= '0; ry_q <= '0; k_q <= KW'(SW);
							sx_q <= '0; sy_q <= '0;
							valid <= 1'b0;
							state_q <= DIV;
						end else begin
							centroid_x <= hx_q; centroid_y <= hy_q;
							valid <= 1'b1;
							if (item.last) begin
								sx_q <= '0; sy_q <= '0; n_q <= '0;
							end else begin
								sx_q <= sx_n; sy_q <= sy_n; n_q <= n_n;
							end
						end
					end else if (ready) begin
						valid <= 1'b0;
					end
				end
				DIV: begin
					if (tx >= {1'b0, n_q}) rx_q <= tx - {1'b0, n_q};
					else rx_q <= tx;
					if (ty >= {1'b0, n_q}) ry_q <= ty - {1'b0, n_q};
					else ry_q <= ty;
					qx_q <= {qx_q[SW-2:0], tx >= {1'b0, n_q}};
					qy_q <= {qy_q[SW-2:0], ty >= {1'b0, n_q}};
					k_q <= k_q - KW'(1);
					if (k_q == KW'(1)) state_q <= SEND;
				end
				SEND: begin
					hx_q <= qx_q[9:0]; hy_q <= qy_q[9:0];
					centroid_x <= qx_q[9:0]; centroid_y <= qy_q[9:0];
					n_q <= '0; valid <= 1'b1; state_q <= RUN;
				end
				default: state_q <= RUN;
			endcase
		end
	end
endmodule

// File: rtl/hsv_color_mask_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_color_mask_centroid
// hsv color mask with per-frame hit centroid
// ----------------------------------------------------------------------------
// One pixel beat is taken per clock, unless a handshake stalls, through a
// two-stage classifier and a four-entry queue into the accumulator. On the
// last pixel of a frame with hits the back end runs a restoring divider per
// axis, one quotient bit per cycle, so that beat leaves after the DIV and
// SEND states, while the queue keeps absorbing pixels until it fills.
module hsv_color_mask_centroid (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        pixel_hit,
	output logic        frame_end,
	output logic        centroid_valid,
	output logic [9:0]  centroid_x,
	output logic [9:0]  centroid_y,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [1:0]  preset_q;
	logic [10:0] fw_q, fh_q;
	logic        fv, fr, bv, br;
	hcmc_pkg::item_t fi, bi;
	logic [1:0]  ridx;

	assign pready = 1'b1;
	assign ridx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= '0; fw_q <= 11'd640; fh_q <= 11'd480;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				hcmc_pkg::RegPreset: preset_q <= pwdata[1:0];
				hcmc_pkg::RegWidth:  fw_q <= pwdata[10:0];
				hcmc_pkg::RegHeight: fh_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			hcmc_pkg::RegPreset: prdata = {30'b0, preset_q};
			hcmc_pkg::RegWidth:  prdata = {21'b0, fw_q};
			hcmc_pkg::RegHeight: prdata = {21'b0, fh_q};
			default: prdata = '0;
		endcase
	end

	hcmc_front u_front (.clk, .arst_n, .valid, .ready, .red, .green, .blue,
		.preset(preset_q), .fw(fw_q), .fh(fh_q),
		.item_valid(fv), .item_ready(fr), .item(fi));

	hcmc_queue u_queue (.clk, .arst_n, .in_valid(fv), .in_ready(fr), .in_item(fi),
		.out_valid(bv), .out_ready(br), .out_item(bi));

	hcmc_back u_back (.clk, .arst_n, .item_valid(bv), .item_ready(br), .item(bi),
		.valid(out_valid), .ready(out_ready), .out_red, .out_green, .out_blue,
		.pixel_hit, .frame_end, .centroid_valid, .centroid_x, .centroid_y);

	a_mask_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_hit |-> out_red == '0 && out_green == '0 && out_blue == '0)
		else $error("masked pixel not black");
	a_cv_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && centroid_valid |-> frame_end)
		else $error("centroid valid outside frame end");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end && $past(out_valid && out_ready) |-> $stable(centroid_x))
		else $error("centroid moved mid frame");
endmodule

// File: verif/hsv_color_mask_centroid_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_color_mask_centroid_tb
// Checks the color mask and the frame centroid against a cycle-free predictor.
// A directed pixel table runs first. Random phases follow, each with its own
// preset and frame size, and include zero, oversize and mid-frame size
// changes. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module hsv_color_mask_centroid_tb;

	localparam int IdleLimit = 3000;
	localparam int NumPhases = 16;

	localparam logic [1:0] PresetYellow  = 2'd0;
	localparam logic [1:0] PresetGreen   = 2'd1;
	localparam logic [1:0] PresetBlue    = 2'd2;
	localparam logic [1:0] PresetVivid   = 2'd3;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		bit         hit;
		bit         fend;
		bit         cval;
		logic [9:0] cx;
		logic [9:0] cy;
	} pixel_res_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		bit         is_miss;
	} pixel_row_t;

	logic        clk;
	logic        arst_n;
	logic        valid;
	logic        ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic        pixel_hit;
	logic        frame_end;
	logic        centroid_valid;
	logic [9:0]  centroid_x;
	logic [9:0]  centroid_y;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	hsv_color_mask_centroid dut (.*);

	// predictor state
	logic [1:0]  cur_preset;
	logic [10:0] cur_width;
	logic [10:0] cur_height;
	int unsigned col_pos;
	int unsigned row_pos;
	longint unsigned col_sum;
	longint unsigned row_sum;
	int unsigned hits_in_frame;
	logic [9:0]  held_x;
	logic [9:0]  held_y;

	pixel_res_t  expected_pixels[$];
	int          errors;
	int          pixels_sent;
	int          frames_seen;
	int          hits_seen;
	int          idle_cycles;
	bit          calm;
	pixel_row_t  pixel_table[14];

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit hsv_hit(int r, int g, int b, logic [1:0] p);
		int mx, mn, diff, sect, delta, hnum, lo, hi;
		if (r > g) begin
			if (r > b) begin
				mx = r; diff = g - b; sect = 0; mn = (g > b) ? b : g;
			end else begin
				mx = b; diff = r - g; mn = g; sect = 4;
			end
		end else begin
			if (r > b) begin
				mx = g; diff = b - r; mn = b; sect = 2;
			end else if (g > b) begin
				mx = g; diff = b - r; mn = r; sect = 2;
			end else begin
				mx = b; diff = r - g; mn = r; sect = 4;
			end
		end
		delta = mx - mn;
		if (delta == 0 || mx < 1)
			return 1'b0;
		hnum = 60 * (sect * delta + diff);
		if (hnum < 0)
			hnum += 360 * delta;
		if (hnum > 360 * delta)
			hnum -= 360 * delta;
		case (p)
			PresetYellow: begin lo = 45;  hi = 64;  end
			PresetGreen:  begin lo = 64;  hi = 150; end
			PresetBlue:   begin lo = 180; hi = 255; end
			default:      begin lo = 11;  hi = 351; end
		endcase
		if (!(hnum > lo * delta && hnum < hi * delta))
			return 1'b0;
		if (p == PresetVivid)
			return 10 * delta > 7 * mx;
		return 100 * delta > 15 * mx;
	endfunction

	function automatic int unsigned frame_dim(logic [10:0] v, int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return 32'(v);
	endfunction

	function automatic pixel_res_t mask_and_track(logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		pixel_res_t  res;
		bit          hit, row_end, last;
		int unsigned w, h;
		hit = hsv_hit(int'(r), int'(g), int'(b), cur_preset);
		if (hit) begin
			col_sum += 64'(col_pos);
			row_sum += 64'(row_pos);
			hits_in_frame++;
		end
		w = frame_dim(cur_width, hcmc_pkg::MaxWidth);
		h = frame_dim(cur_height, hcmc_pkg::MaxHeight);
		row_end = col_pos >= w - 1;
		last = row_end && row_pos >= h - 1;
		res.cval = 1'b0;
		if (row_end) begin
			col_pos = 0;
			row_pos = last ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
		if (last) begin
			if (hits_in_frame > 0) begin
				res.cval = 1'b1;
				held_x = 10'(col_sum / hits_in_frame);
				held_y = 10'(row_sum / hits_in_frame);
			end
			col_sum = 0;
			row_sum = 0;
			hits_in_frame = 0;
		end
		res.r = hit ? r : 8'd0;
		res.g = hit ? g : 8'd0;
		res.b = hit ? b : 8'd0;
		res.hit = hit;
		res.fend = last;
		res.cx = held_x;
		res.cy = held_y;
		return res;
	endfunction

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit is_miss);
		pixel_res_t res;
		valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (!ready);
		res = mask_and_track(r, g, b);
		if (is_miss) begin
			res.r = 8'd0;
			res.g = 8'd0;
			res.b = 8'd0;
			res.hit = 1'b0;
		end
		expected_pixels.push_back(res);
		pixels_sent++;
		if (!calm && $urandom_range(0, 99) < 36) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic random_pixel();
		int mx, mn, md, kind;
		logic [7:0] c[3];
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
		end else if (kind == 1) begin
			mx = $urandom_range(0, 255);
			send_pixel(8'(mx), 8'(mx), 8'(mx), 1'b0);
		end else begin
			mx = $urandom_range(1, 255);
			mn = $urandom_range(0, mx);
			md = $urandom_range(mn, mx);
			case ($urandom_range(0, 5))
				0: begin c[0] = 8'(mx); c[1] = 8'(md); c[2] = 8'(mn); end
				1: begin c[0] = 8'(mx); c[1] = 8'(mn); c[2] = 8'(md); end
				2: begin c[0] = 8'(md); c[1] = 8'(mx); c[2] = 8'(mn); end
				3: begin c[0] = 8'(mn); c[1] = 8'(mx); c[2] = 8'(md); end
				4: begin c[0] = 8'(md); c[1] = 8'(mn); c[2] = 8'(mx); end
				default: begin c[0] = 8'(mn); c[1] = 8'(md); c[2] = 8'(mx); end
			endcase
			send_pixel(c[0], c[1], c[2], 1'b0);
		end
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			hcmc_pkg::RegPreset: cur_preset = data[1:0];
			hcmc_pkg::RegWidth:  cur_width = data[10:0];
			hcmc_pkg::RegHeight: cur_height = data[10:0];
			default: ;
		endcase
	endtask

	task automatic drain_and_configure(logic [1:0] p, logic [10:0] w, logic [10:0] h);
		valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		reg_write(hcmc_pkg::RegPreset, 32'(p));
		reg_write(hcmc_pkg::RegWidth, 32'(w));
		reg_write(hcmc_pkg::RegHeight, 32'(h));
	endtask

	always @(posedge clk) begin
		pixel_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected output beat", $time);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				if (frame_end)
					frames_seen++;
				if (pixel_hit)
					hits_seen++;
				if (out_red !== want.r || out_green !== want.g || out_blue !== want.b) begin
					$display("%0t: rgb expected %h %h %h got %h %h %h", $time,
						want.r, want.g, want.b, out_red, out_green, out_blue);
					errors++;
				end
				if (pixel_hit !== want.hit) begin
					$display("%0t: pixel_hit expected %b got %b", $time, want.hit, pixel_hit);
					errors++;
				end
				if (frame_end !== want.fend) begin
					$display("%0t: frame_end expected %b got %b", $time, want.fend, frame_end);
					errors++;
				end
				if (centroid_valid !== want.cval) begin
					$display("%0t: centroid_valid expected %b got %b", $time,
						want.cval, centroid_valid);
					errors++;
				end
				if (centroid_x !== want.cx || centroid_y !== want.cy) begin
					$display("%0t: centroid expected %0d,%0d got %0d,%0d", $time,
						want.cx, want.cy, centroid_x, centroid_y);
					errors++;
				end
			end
		end
		out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 36);
	end

	always @(posedge clk) begin
		if (!arst_n || (valid && ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t: watchdog expired, %0d beats outstanding", $time,
					expected_pixels.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int n;
		logic [10:0] w, h;
		arst_n = 1'b0;
		valid = 1'b0;
		red = 8'd0;
		green = 8'd0;
		blue = 8'd0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 4'd0;
		pwdata = 32'd0;
		errors = 0;
		pixels_sent = 0;
		frames_seen = 0;
		hits_seen = 0;
		idle_cycles = 0;
		calm = 1'b0;
		cur_preset = PresetYellow;
		cur_width = 11'd640;
		cur_height = 11'd480;
		col_pos = 0;
		row_pos = 0;
		col_sum = 0;
		row_sum = 0;
		hits_in_frame = 0;
		held_x = 10'd0;
		held_y = 10'd0;
		pixel_table = '{
			'{8'd0,   8'd0,   8'd0,   1'b1},
			'{8'd255, 8'd255, 8'd255, 1'b1},
			'{8'd128, 8'd128, 8'd128, 1'b1},
			'{8'd1,   8'd1,   8'd1,   1'b1},
			'{8'd255, 8'd0,   8'd0,   1'b0},
			'{8'd255, 8'd255, 8'd0,   1'b0},
			'{8'd255, 8'd200, 8'd0,   1'b0},
			'{8'd0,   8'd255, 8'd0,   1'b0},
			'{8'd0,   8'd0,   8'd255, 1'b0},
			'{8'd255, 8'd0,   8'd255, 1'b0},
			'{8'd255, 8'd0,   8'd40,  1'b0},
			'{8'd1,   8'd0,   8'd0,   1'b0},
			'{8'd0,   8'd1,   8'd0,   1'b0},
			'{8'd255, 8'd255, 8'd254, 1'b0}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (pixel_table[i])
			send_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b,
				pixel_table[i].is_miss);

		for (int ph = 0; ph < NumPhases; ph++) begin
			n = 50;
			case (ph)
				0: begin w = 11'd0; h = 11'd0; end
				1: begin w = 11'd2047; h = 11'd2047; n = 40; end
				2: begin w = 11'd3; h = 11'd1; end
				3: begin w = 11'd1024; h = 11'd1; n = 30; end
				4: begin w = 11'd1; h = 11'd1024; n = 30; end
				5: begin w = 11'd2; h = 11'd0; end
				default: begin
					w = 11'($urandom_range(1, 8));
					h = 11'($urandom_range(1, 6));
				end
			endcase
			drain_and_configure(2'(ph), w, h);
			calm = (ph == 7 || ph == 8);
			repeat (n)
				random_pixel();
			if (ph == 3)
				drain_and_configure(PresetVivid, 11'd1, 11'd1);
		end
		calm = 1'b0;
		valid <= 1'b0;

		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d pixels over all four presets, %0d frame ends, %0d hits",
			pixels_sent, frames_seen, hits_seen);
		$display("frame sizes included zero, oversize and changes in the middle of a frame");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
